// ----- design/lfo_pkg.sv -----
// lfo_pkg: shared types and constants for the multi-shape lfo
// no dependencies
`timescale 1ns / 1ps

package lfo_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned SHAPE_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd1;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_TRIANGLE  = 3'd0,
    SHAPE_SQUARE    = 3'd1,
    SHAPE_RAMP_UP   = 3'd2,
    SHAPE_RAMP_DOWN = 3'd3,
    SHAPE_SAMPLE_HOLD = 3'd4,
    SHAPE_BINARY_RND  = 3'd5,
    SHAPE_LINES     = 3'd6,
    SHAPE_NOISE     = 3'd7
  } shape_t;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hffff;

endpackage

// ----- design/multi_shape_lfo_top.sv -----
// multi_shape_lfo_top: phase accumulator lfo with eight output shapes
// depends on lfo_pkg
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+-------------------------------
// in       | in_valid / in_stall  | in_random_word [15:0]
// out      | out_valid / out_stall| out_sample [15:0]
// cfg      | cfg_valid / cfg_ready| cfg_index [1:0], cfg_data [31:0]
//
// one tick per cycle unless stalled: a transaction on in is computed in one pass
// and lands in the output register on the accepting edge, raising out_valid.
// the longest path is the 17x17 signed multiply of the lines shape.
// in_stall is high only while a finished sample sits in the output register
// and out_stall holds it; a sample taken in the same cycle frees the slot.
// rst_n is synchronous and active low; it clears phase, wrap flag, held
// values, the config registers and out_valid. cfg_ready is always high.

module multi_shape_lfo_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lfo_pkg::SAMPLE_W-1:0]  in_random_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfo_pkg::SAMPLE_W-1:0]  out_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfo_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lfo_pkg::*;

  // configuration
  shape_t               shape_r;
  logic [PHASE_W-1:0]   phase_step_r;

  // oscillator state
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic                 wrapped_r, wrapped_nxt;
  logic [SAMPLE_W-1:0]  held_r, held_nxt;
  logic [SAMPLE_W-1:0]  target_r, target_nxt;

  // output register
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_sample_r, sample_nxt;

  logic                 in_accept;
  logic [SAMPLE_W-1:0]  frac;
  logic [SAMPLE_W-1:0]  tri_bits;
  logic [SAMPLE_W-1:0]  lines_held;
  logic [SAMPLE_W-1:0]  lines_target;
  logic signed [SAMPLE_W:0]     diff;
  logic signed [2*SAMPLE_W:0]   prod;
  logic [SAMPLE_W-1:0]  lerp_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;

  assign frac     = phase_r[PHASE_W-1 -: SAMPLE_W];
  assign tri_bits = phase_r[PHASE_W-2 -: SAMPLE_W];

  // accumulator advance, carry out is the wrap flag
  assign {wrapped_nxt, phase_nxt} = {1'b0, phase_r} + {1'b0, phase_step_r};

  // segment end points for the lines shape, shifted along after a wrap
  assign lines_held   = wrapped_r ? target_r : held_r;
  assign lines_target = wrapped_r ? in_random_word : target_r;

  // interpolation: held + floor((target - held) * frac / 2^16)
  assign diff   = $signed({1'b0, lines_target}) - $signed({1'b0, lines_held});
  assign prod   = diff * $signed({1'b0, frac});
  // arithmetic shift gives the floor for negative products
  assign lerp_q = lines_held + prod[SAMPLE_W +: SAMPLE_W];

  always_comb begin
    held_nxt   = held_r;
    target_nxt = target_r;
    sample_nxt = '0;
    case (shape_r)
      SHAPE_TRIANGLE: begin
        sample_nxt = phase_r[PHASE_W-1] ? tri_bits : ~tri_bits;
      end
      SHAPE_SQUARE: begin
        sample_nxt = phase_r[PHASE_W-1] ? SAMPLE_MAX : '0;
      end
      SHAPE_RAMP_UP: begin
        sample_nxt = frac;
      end
      SHAPE_RAMP_DOWN: begin
        sample_nxt = ~frac;
      end
      SHAPE_SAMPLE_HOLD: begin
        if (wrapped_r) held_nxt = in_random_word;
        sample_nxt = held_nxt;
      end
      SHAPE_BINARY_RND: begin
        if (wrapped_r) held_nxt = in_random_word[0] ? SAMPLE_MAX : '0;
        sample_nxt = held_nxt;
      end
      SHAPE_LINES: begin
        held_nxt   = lines_held;
        target_nxt = lines_target;
        sample_nxt = lerp_q;
      end
      SHAPE_NOISE: begin
        sample_nxt = in_random_word;
      end
      default: begin
        sample_nxt = in_random_word;
      end
    endcase
  end

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r      <= SHAPE_TRIANGLE;
      phase_step_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAVE_SHAPE: shape_r      <= shape_t'(cfg_data[SHAPE_W-1:0]);
        REG_PHASE_STEP: phase_step_r <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      wrapped_r <= 1'b0;
      held_r    <= '0;
      target_r  <= '0;
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      wrapped_r <= wrapped_nxt;
      held_r    <= held_nxt;
      target_r  <= target_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_sample_r <= sample_nxt;
    end
  end

  // a pending sample that is held back blocks new ticks
  a_block_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("tick accepted while output register full");

  // every accepted tick shows up in the output register
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted tick produced no sample");

  // zero step leaves the phase in place and never wraps
  a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_step_r == '0) |=> (phase_r == $past(phase_r) && !wrapped_r))
    else $error("phase moved with zero step");

  // square shape is rail to rail only
  a_square_rails: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && shape_r == SHAPE_SQUARE) |=>
      (out_sample_r == '0 || out_sample_r == SAMPLE_MAX))
    else $error("square sample off the rails");

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for multi_shape_lfo_top, one lfo tick per transaction
// depends on lfo_pkg and multi_shape_lfo_top
`timescale 1ns / 1ps

// expected-sample tracker: mirrors the oscillator state and holds the samples still owed
class lfo_sample_board;
  lfo_pkg::shape_t shape;
  logic [31:0]     step;
  logic [31:0]     phase;
  logic            wrapped;
  logic [15:0]     held;
  logic [15:0]     target;
  logic [15:0]     owed_samples[$];
  int              mismatches;
  int              samples_checked;

  function new();
    shape           = lfo_pkg::SHAPE_TRIANGLE;
    step            = '0;
    phase           = '0;
    wrapped         = 1'b0;
    held            = '0;
    target          = '0;
    mismatches      = 0;
    samples_checked = 0;
  endfunction

  function void write_reg(logic [lfo_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    if (idx == lfo_pkg::REG_WAVE_SHAPE) begin
      shape = lfo_pkg::shape_t'(data[2:0]);
    end else if (idx == lfo_pkg::REG_PHASE_STEP) begin
      step = data;
    end
  endfunction

  // sample comes from the phase before this tick's advance
  function void note_tick(logic [15:0] word);
    logic [15:0] s;
    logic [32:0] sum;
    longint      prod;
    s = '0;
    case (shape)
      lfo_pkg::SHAPE_TRIANGLE:  s = phase[31] ? phase[30:15] : ~phase[30:15];
      lfo_pkg::SHAPE_SQUARE:    s = phase[31] ? lfo_pkg::SAMPLE_MAX : '0;
      lfo_pkg::SHAPE_RAMP_UP:   s = phase[31:16];
      lfo_pkg::SHAPE_RAMP_DOWN: s = ~phase[31:16];
      lfo_pkg::SHAPE_SAMPLE_HOLD: begin
        if (wrapped) held = word;
        s = held;
      end
      lfo_pkg::SHAPE_BINARY_RND: begin
        if (wrapped) held = word[0] ? lfo_pkg::SAMPLE_MAX : '0;
        s = held;
      end
      lfo_pkg::SHAPE_LINES: begin
        if (wrapped) begin
          held   = target;
          target = word;
        end
        // signed difference times fraction, floored by the arithmetic shift
        prod = (longint'(target) - longint'(held)) * longint'(phase[31:16]);
        prod = prod >>> 16;
        s    = held + prod[15:0];
      end
      default: s = word;
    endcase
    sum     = {1'b0, phase} + {1'b0, step};
    phase   = sum[31:0];
    wrapped = sum[32];
    owed_samples.push_back(s);
  endfunction

  function void check_sample(logic [15:0] got);
    logic [15:0] exp_s;
    if (owed_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("sample %h arrived with none outstanding", got);
    end else begin
      exp_s = owed_samples.pop_front();
      samples_checked++;
      if (got !== exp_s) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("sample %0d mismatch: expected %h got %h", samples_checked, exp_s, got);
        end
      end
    end
  endfunction
endclass

module tb_top;
  import lfo_pkg::*;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_random_word = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [SAMPLE_W-1:0]  out_sample;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_DAT_W-1:0] cfg_data       = '0;

  lfo_sample_board board = new();

  // run bookkeeping for the summary
  int         ticks_sent    = 0;
  int         settings_used = 0;
  logic [7:0] shapes_seen   = '0;
  // when clear, both sides run back to back with no idle cycles
  bit         gaps_on       = 1'b1;

  multi_shape_lfo_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_random_word (in_random_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // one tick: optional idle gap, then hold valid until the transaction goes through
  task automatic send_tick(input logic [SAMPLE_W-1:0] word);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_random_word <= word;
    do @(posedge clk); while (in_stall);
    board.note_tick(word);
    ticks_sent++;
  endtask

  // drop valid and wait for every owed sample, bounded so a hung block cannot stall us
  task automatic drain;
    int n;
    in_valid <= 1'b0;
    for (n = 0; n < 5000 && board.owed_samples.size() != 0; n++) @(posedge clk);
    // one tick per transaction, then wait out the output register
    repeat (2) @(posedge clk);
  endtask

  // writes both registers back to back while the block is idle
  task automatic configure(input shape_t shp, input logic [CFG_DAT_W-1:0] step_val);
    logic [CFG_DAT_W-1:0] shape_word;
    drain;
    // junk in the unused upper bits of the shape write half the time
    shape_word      = $urandom_range(0, 1) ? $urandom : '0;
    shape_word[2:0] = shp;
    cfg_valid <= 1'b1;
    cfg_index <= REG_WAVE_SHAPE;
    cfg_data  <= shape_word;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(REG_WAVE_SHAPE, shape_word);
    cfg_index <= REG_PHASE_STEP;
    cfg_data  <= step_val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(REG_PHASE_STEP, step_val);
    cfg_valid <= 1'b0;
    settings_used++;
    shapes_seen[shp] = 1'b1;
  endtask

  // steps: still, wrap almost every tick, half turn, slow, medium and anything
  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 6))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'($urandom_range(1, 16'hffff));
      4:       return 32'($urandom_range(1, 255)) << 24;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return SAMPLE_MAX;
      default: return SAMPLE_W'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // result side: random stall stretch, then take and check one sample
  initial begin
    int hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = gaps_on ? $urandom_range(0, 15) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      board.check_sample(out_sample);
    end
  end

  // stimulus
  initial begin
    int run_len;
    int leftover;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: triangle with the phase parked at zero
    send_tick(16'h0000);
    // zero step, noise passes every word straight through
    configure(SHAPE_NOISE, 32'h0);
    send_tick(16'h0000); send_tick(16'hffff); send_tick(16'haaaa); send_tick(16'h5555);
    // quarter turns walk the triangle through both halves
    configure(SHAPE_TRIANGLE, 32'h4000_0000);
    send_tick(16'h1111); send_tick(16'h2222); send_tick(16'h3333);
    configure(SHAPE_SQUARE, 32'h8000_0000);
    send_tick(16'hffff); send_tick(16'h0000);
    // largest step, phase runs backwards and wraps almost every tick
    configure(SHAPE_RAMP_UP, 32'hffff_ffff);
    send_tick(16'h0001); send_tick(16'h8000);
    configure(SHAPE_RAMP_DOWN, 32'h1234_5678);
    send_tick(16'hfffe); send_tick(16'h7fff);
    // wrap flag carried over from earlier shapes picks up new values here
    configure(SHAPE_SAMPLE_HOLD, 32'h8000_0000);
    send_tick(16'hffff); send_tick(16'h1234); send_tick(16'h0000);
    configure(SHAPE_BINARY_RND, 32'hffff_ffff);
    send_tick(16'h0001); send_tick(16'h0000); send_tick(16'hffff);
    // lines with rising and falling segments
    configure(SHAPE_LINES, 32'h4000_0000);
    send_tick(16'hffff); send_tick(16'h0000); send_tick(16'h8000);
    send_tick(16'h7fff); send_tick(16'h1234);

    // random part: random settings, runs of random ticks, idling on most runs
    while (ticks_sent < 925) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      configure(shape_t'(3'($urandom_range(0, 7))), pick_step());
      run_len = $urandom_range(10, 60);
      repeat (run_len) send_tick(pick_word());
    end

    drain;
    repeat (5) @(posedge clk);
    leftover = board.owed_samples.size();
    if (leftover != 0) begin
      board.mismatches += leftover;
      $display("%0d samples never arrived", leftover);
    end
    $display("covered %0d ticks under %0d register settings, shapes seen %b",
             ticks_sent, settings_used, shapes_seen);
    $display("%0d samples checked, %0d mismatches", board.samples_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lfo_pkg.sv
design/multi_shape_lfo_top.sv
test/tb_top.sv
